FILE: rtl/rfifo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO package
// Beat types, function codes and default sizes shared by the ring FIFO RTL.
// ----------------------------------------------------------------------------
package rfifo_pkg;

  localparam int unsigned DEPTH_DEFAULT      = 16;
  localparam int unsigned DATA_WIDTH_DEFAULT = 32;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 4;

  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] data_in;
  } rfifo_in_t;

  typedef struct packed {
    logic              status;
    logic [WORD_W-1:0] pop_data;
    logic [WORD_W-1:0] front_value;
    logic [WORD_W-1:0] back_value;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
    logic              is_full;
  } rfifo_out_t;

endpackage

FILE: rtl/ring_fifo_one_slot_empty_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ring FIFO with one slot left empty
// Circular queue of DEPTH slots holding at most DEPTH-1 entries, with a
// push / pop / status command channel and a one-beat status response.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one command
//   beat: push data_in, pop the front, or query status. Each command gives
//   exactly one response beat on the output channel (out_valid_o /
//   out_ready_i / out_data_o) with the reject status, popped word, front and
//   back words, occupancy and empty/full flags after the command.
//   Slots live in a memory with one write port and two registered read
//   ports. The popped word is read at the accept edge, the front and back
//   words of the updated queue at the next edge, and the response is
//   registered once the output channel is free. A new command is taken
//   only after the response to the last command has been registered.
//   Reset clears both pointers, leaving the queue empty; slot contents are
//   not cleared and need no clearing pass. When the receiver stalls, the
//   response is held and the next finished response waits in the sequencer,
//   so at most one further command is accepted.
// ----------------------------------------------------------------------------
module ring_fifo_one_slot_empty_top #(
  parameter int unsigned DEPTH      = rfifo_pkg::DEPTH_DEFAULT,
  parameter int unsigned DATA_WIDTH = rfifo_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  rfifo_pkg::rfifo_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output rfifo_pkg::rfifo_out_t  out_data_o
);
  import rfifo_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FRONT = 2'd1;
  localparam logic [1:0] ST_FIN   = 2'd2;

  logic [DATA_WIDTH-1:0] slot_mem [DEPTH];

  logic [1:0]            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [AW-1:0]         tail_q, tail_d;
  logic                  status_q, status_d;
  logic                  pop_ok_q, pop_ok_d;
  logic [WORD_W-1:0]     pop_q, pop_d;
  logic [DATA_WIDTH-1:0] rd_a_q, rd_b_q;
  logic                  out_valid_q, out_valid_d;
  rfifo_out_t            out_q, out_d;

  logic          in_acc;
  logic          out_free;
  logic          empty, full;
  logic          push_ok, pop_ok;
  logic [AW-1:0] head_nxt, tail_nxt, tail_prev;
  logic [AW:0]   count;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign head_nxt  = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign tail_nxt  = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
  assign tail_prev = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);
  assign empty     = (head_q == tail_q);
  assign full      = (tail_nxt == head_q);
  assign count     = (tail_q >= head_q) ? {1'b0, tail_q} - {1'b0, head_q}
                                        : {1'b0, tail_q} + (AW+1)'(DEPTH) - {1'b0, head_q};

  assign push_ok = (in_data_i.func == FUNC_PUSH) && !full;
  assign pop_ok  = (in_data_i.func == FUNC_POP) && !empty;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    status_d    = status_q;
    pop_ok_d    = pop_ok_q;
    pop_d       = pop_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          status_d = ((in_data_i.func == FUNC_PUSH) && full) ||
                     ((in_data_i.func == FUNC_POP) && empty);
          pop_ok_d = pop_ok;
          if (push_ok) begin
            tail_d = tail_nxt;
          end
          if (pop_ok) begin
            head_d = head_nxt;
          end
          state_d = ST_FRONT;
        end
      end
      ST_FRONT: begin
        pop_d   = pop_ok_q ? WORD_W'(rd_a_q) : '0;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_d.status      = status_q;
          out_d.pop_data    = pop_q;
          out_d.front_value = empty ? '0 : WORD_W'(rd_a_q);
          out_d.back_value  = empty ? '0 : WORD_W'(rd_b_q);
          out_d.occupancy   = OCC_W'(count);
          out_d.is_empty    = empty;
          out_d.is_full     = full;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    pop_ok_q <= pop_ok_d;
    pop_q    <= pop_d;
    out_q    <= out_d;
  end

  // write on push, read head and last entry every cycle
  always_ff @(posedge clk_i) begin
    if (in_acc && push_ok) begin
      slot_mem[tail_q] <= DATA_WIDTH'(in_data_i.data_in);
    end
    rd_a_q <= slot_mem[head_q];
    rd_b_q <= slot_mem[tail_prev];
  end

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(head_q) < DEPTH) && (int'(tail_q) < DEPTH))
    else $error("ring fifo pointer out of range");

  a_accept_locks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o ##1 !in_ready_o)
    else $error("ring fifo accepted a beat while busy");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_empty) |->
      (out_data_o.front_value == '0) && (out_data_o.back_value == '0) &&
      (out_data_o.occupancy == '0) && !out_data_o.is_full)
    else $error("ring fifo empty response carries data");

  a_ptr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(head_q) && $stable(tail_q))
    else $error("ring fifo pointers moved without a command");

endmodule
